// ===== rtl/fpws_pkg.sv =====
// Shared constants, control types and microprogram for the flash page write splitter.
package fpws_pkg;

  localparam int PAGE_BYTES = 256;
  localparam int MAX_BYTES  = 4096;

  localparam int ADDR_W    = 24;
  localparam int CNT_W     = 13;
  localparam int LEN_W     = 9;
  localparam int PAGE_LOG2 = $clog2(PAGE_BYTES);

  localparam int STEP_W = 1;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_IDLE = step_t'(0);
  localparam step_t STEP_EMIT = step_t'(1);

  // what a step waits for before its action fires and the step counter moves
  typedef enum logic {
    WAIT_IN,
    WAIT_OUT
  } wait_t;

  // branch condition tested once the step fires
  typedef enum logic {
    COND_ALWAYS,
    COND_LAST
  } cond_t;

  typedef struct packed {
    wait_t wait_on;
    logic  load;
    logic  emit;
    cond_t cond;
    step_t jmp;
    step_t nxt;
  } uword_t;

  // sequencer to datapath
  typedef struct packed {
    logic take_in;
    logic do_emit;
    logic in_ready;
  } seq_ctrl_t;

  // datapath to sequencer
  typedef struct packed {
    logic out_free;
    logic last;
  } dp_stat_t;

  function automatic uword_t ucode(input step_t step);
    uword_t w;
    w = '{wait_on: WAIT_IN, load: 1'b0, emit: 1'b0, cond: COND_ALWAYS,
          jmp: STEP_IDLE, nxt: STEP_IDLE};
    case (step)
      STEP_IDLE: begin
        w = '{wait_on: WAIT_IN, load: 1'b1, emit: 1'b0, cond: COND_ALWAYS,
              jmp: STEP_EMIT, nxt: STEP_EMIT};
      end
      STEP_EMIT: begin
        w = '{wait_on: WAIT_OUT, load: 1'b0, emit: 1'b1, cond: COND_LAST,
              jmp: STEP_IDLE, nxt: STEP_EMIT};
      end
      default: begin
        w = '{wait_on: WAIT_IN, load: 1'b0, emit: 1'b0, cond: COND_ALWAYS,
              jmp: STEP_IDLE, nxt: STEP_IDLE};
      end
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/fpws_seq.sv =====
// Microcode sequencer: step counter, control store and conditional jumps.
module fpws_seq (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  fpws_pkg::dp_stat_t   stat,
  output fpws_pkg::seq_ctrl_t  ctrl
);

  fpws_pkg::step_t  step;
  fpws_pkg::step_t  step_next;
  fpws_pkg::uword_t uw;
  logic             go;
  logic             taken;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= fpws_pkg::STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

  always_comb begin
    uw = fpws_pkg::ucode(step);
    case (uw.wait_on)
      fpws_pkg::WAIT_IN:  go = in_valid;
      fpws_pkg::WAIT_OUT: go = stat.out_free;
      default:            go = 1'b0;
    endcase
    case (uw.cond)
      fpws_pkg::COND_ALWAYS: taken = 1'b1;
      fpws_pkg::COND_LAST:   taken = stat.last;
      default:               taken = 1'b0;
    endcase
    step_next = step;
    if (go) begin
      step_next = taken ? uw.jmp : uw.nxt;
    end
    ctrl.take_in  = go & uw.load;
    ctrl.do_emit  = go & uw.emit;
    ctrl.in_ready = uw.load;
  end

endmodule

// ===== rtl/fpws_dp.sv =====
// Datapath: request registers, chunk length arithmetic and output register.
module fpws_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  fpws_pkg::seq_ctrl_t                 ctrl,
  input  logic [fpws_pkg::ADDR_W-1:0]         start_address,
  input  logic [fpws_pkg::CNT_W-1:0]          byte_count,
  input  logic                                out_stall,
  output fpws_pkg::dp_stat_t                  stat,
  output logic                                out_valid,
  output logic [fpws_pkg::ADDR_W-1:0]         chunk_address,
  output logic [fpws_pkg::LEN_W-1:0]          chunk_length,
  output logic [fpws_pkg::CNT_W-1:0]          buffer_offset,
  output logic                                last_chunk
);

  localparam logic [fpws_pkg::LEN_W-1:0] PAGE_LEN = fpws_pkg::LEN_W'(fpws_pkg::PAGE_BYTES);
  localparam logic [fpws_pkg::CNT_W-1:0] MAX_CNT  = fpws_pkg::CNT_W'(fpws_pkg::MAX_BYTES);

  logic [fpws_pkg::ADDR_W-1:0] addr;
  logic [fpws_pkg::CNT_W-1:0]  rem;
  logic [fpws_pkg::CNT_W-1:0]  off;
  logic [fpws_pkg::LEN_W-1:0]  page_rem;
  logic [fpws_pkg::LEN_W-1:0]  len;
  logic [fpws_pkg::CNT_W-1:0]  rem_after;
  logic [fpws_pkg::CNT_W-1:0]  count_sat;

  always_comb begin
    page_rem  = PAGE_LEN - fpws_pkg::LEN_W'(addr[fpws_pkg::PAGE_LOG2-1:0]);
    if (rem < fpws_pkg::CNT_W'(page_rem)) begin
      len = rem[fpws_pkg::LEN_W-1:0];
    end else begin
      len = page_rem;
    end
    rem_after = rem - fpws_pkg::CNT_W'(len);
    count_sat = (byte_count > MAX_CNT) ? MAX_CNT : byte_count;
    stat.out_free = ~out_valid | ~out_stall;
    stat.last     = (rem_after == '0);
  end

  always_ff @(posedge clk) begin
    if (ctrl.take_in) begin
      addr <= start_address;
      rem  <= count_sat;
      off  <= '0;
    end else if (ctrl.do_emit) begin
      addr <= addr + fpws_pkg::ADDR_W'(len);
      rem  <= rem_after;
      off  <= off + fpws_pkg::CNT_W'(len);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.do_emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.do_emit) begin
      chunk_address <= addr;
      chunk_length  <= len;
      buffer_offset <= off;
      last_chunk    <= stat.last;
    end
  end

`ifndef SYNTH
  a_no_load_and_emit: assert property (@(posedge clk) disable iff (rst)
    !(ctrl.take_in && ctrl.do_emit))
    else $error("request load and chunk emit in the same cycle");

  a_inner_chunk_ends_on_page: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_chunk |->
      (fpws_pkg::LEN_W'(chunk_address[fpws_pkg::PAGE_LOG2-1:0]) + chunk_length) == PAGE_LEN)
    else $error("non-final chunk does not end on a page boundary");

  a_empty_chunk_only_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && chunk_length == '0 |-> last_chunk && buffer_offset == '0)
    else $error("zero-length chunk inside a non-empty request");
`endif

endmodule

// ===== rtl/flash_page_write_splitter.sv =====
// Top level of the flash page write splitter.
// Takes one write transaction (24-bit flash start address, byte count) and
// emits page-program chunks that never cross a 256-byte page boundary: an
// unaligned start first fills the rest of its page, whole pages follow, then
// a final partial chunk. Each chunk carries its flash address (wrapping at
// 2^24), its length, its offset into the source buffer and a last flag. A
// count above 4096 is treated as 4096; a zero count gives one zero-length
// chunk flagged last. A request yields N = 1..17 chunks: the idle step
// takes the transaction, then the emit step of the microcode sequencer
// produces one chunk per cycle through the length and address adders,
// holding whenever the output register is full and stalled. The
// next request is taken only after the last chunk has entered the output
// register; that register lets the block stay one chunk ahead of a stalled
// consumer.
module flash_page_write_splitter (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [fpws_pkg::ADDR_W-1:0]  start_address,
  input  logic [fpws_pkg::CNT_W-1:0]   byte_count,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [fpws_pkg::ADDR_W-1:0]  chunk_address,
  output logic [fpws_pkg::LEN_W-1:0]   chunk_length,
  output logic [fpws_pkg::CNT_W-1:0]   buffer_offset,
  output logic                         last_chunk
);

  fpws_pkg::seq_ctrl_t ctrl;
  fpws_pkg::dp_stat_t  stat;

  // step counter and control store; decides when to load and when to emit
  fpws_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  // stall the input side in every step but idle
  assign in_stall = ~ctrl.in_ready;

  // address, remaining count and offset registers plus the output register
  fpws_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .start_address (start_address),
    .byte_count    (byte_count),
    .out_stall     (out_stall),
    .stat          (stat),
    .out_valid     (out_valid),
    .chunk_address (chunk_address),
    .chunk_length  (chunk_length),
    .buffer_offset (buffer_offset),
    .last_chunk    (last_chunk)
  );

endmodule

// ===== bench/flash_page_write_splitter_tb.sv =====
// Testbench for the flash page write splitter: random and directed requests, chunk scoreboard.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Give up on a hung run well past the slowest correct one.
  localparam int CYCLE_LIMIT = 1_000_000;
  // Cycles to keep watching after the last chunk, for any stray output.
  localparam int DRAIN_CYCLES = 20;
  // Length of the one long output hold-off that backs the block up.
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int RANDOM_REQUESTS = 200;

  typedef struct packed {
    logic [fpws_pkg::ADDR_W-1:0] address;
    logic [fpws_pkg::LEN_W-1:0]  length;
    logic [fpws_pkg::CNT_W-1:0]  offset;
    logic                        last;
  } chunk_t;

  // Chunk scoreboard: split each accepted request into the chunks it must
  // produce, then match every emitted chunk against the oldest one due.
  class chunk_book_t;
    chunk_t due[$];
    int     errors;

    function new();
      errors = 0;
    endfunction

    function void note_request(input logic [fpws_pkg::ADDR_W-1:0] start,
                               input logic [fpws_pkg::CNT_W-1:0]  count);
      chunk_t      ch;
      int unsigned left;
      int unsigned addr;
      int unsigned off;
      int unsigned len;
      left = count;
      if (left > fpws_pkg::MAX_BYTES) left = fpws_pkg::MAX_BYTES;
      addr = start;
      off  = 0;
      if (left == 0) begin
        ch = '{address: start, length: '0, offset: '0, last: 1'b1};
        due.push_back(ch);
        return;
      end
      while (left > 0) begin
        len = fpws_pkg::PAGE_BYTES - (addr % fpws_pkg::PAGE_BYTES);
        if (len > left) len = left;
        left -= len;
        ch.address = fpws_pkg::ADDR_W'(addr);
        ch.length  = fpws_pkg::LEN_W'(len);
        ch.offset  = fpws_pkg::CNT_W'(off);
        ch.last    = (left == 0);
        due.push_back(ch);
        addr = (addr + len) % (1 << fpws_pkg::ADDR_W);
        off += len;
      end
    endfunction

    function void check_chunk(input chunk_t got);
      chunk_t want;
      if (due.size() == 0) begin
        $error("unexpected chunk: address %h length %0d offset %0d last %0b",
               got.address, got.length, got.offset, got.last);
        errors++;
        return;
      end
      want = due.pop_front();
      if (got.address != want.address) begin
        $error("chunk_address: expected %h, got %h", want.address, got.address);
        errors++;
      end
      if (got.length != want.length) begin
        $error("chunk_length: expected %0d, got %0d", want.length, got.length);
        errors++;
      end
      if (got.offset != want.offset) begin
        $error("buffer_offset: expected %0d, got %0d", want.offset, got.offset);
        errors++;
      end
      if (got.last != want.last) begin
        $error("last_chunk: expected %0b, got %0b", want.last, got.last);
        errors++;
      end
    endfunction

    function int pending();
      return due.size();
    endfunction
  endclass

  logic                        clk;
  logic                        rst;
  logic                        in_valid;
  logic                        in_stall;
  logic [fpws_pkg::ADDR_W-1:0] start_address;
  logic [fpws_pkg::CNT_W-1:0]  byte_count;
  logic                        out_valid;
  logic                        out_stall;
  logic [fpws_pkg::ADDR_W-1:0] chunk_address;
  logic [fpws_pkg::LEN_W-1:0]  chunk_length;
  logic [fpws_pkg::CNT_W-1:0]  buffer_offset;
  logic                        last_chunk;

  chunk_book_t book = new();
  int          requests_taken = 0;
  int          cycles = 0;

  flash_page_write_splitter DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .start_address (start_address),
    .byte_count    (byte_count),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .chunk_address (chunk_address),
    .chunk_length  (chunk_length),
    .buffer_offset (buffer_offset),
    .last_chunk    (last_chunk)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Abort a hung run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Idle length: mostly none, often a few cycles, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one request after an optional idle gap and hold it until the block
  // takes it. Called and returning at a falling edge. Keep in_valid high
  // across back-to-back transactions so it is never dropped and raised in
  // the same step.
  task automatic send_request(input logic [fpws_pkg::ADDR_W-1:0] start,
                              input logic [fpws_pkg::CNT_W-1:0]  count,
                              input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    start_address <= start;
    byte_count    <= count;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    book.note_request(start, count);
    requests_taken++;
    @(negedge clk);
  endtask

  // Score every chunk the block hands over.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      book.check_chunk('{chunk_address, chunk_length, buffer_offset, last_chunk});
  end

  // Consumer side: random stall runs, calm stretches with no stall at all,
  // and one long hold-off once traffic is flowing so the output register
  // fills and the block has to stall its input.
  initial begin : consumer
    int  run;
    int  held;
    bit  pressed;
    out_stall = 1'b0;
    pressed   = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!pressed && requests_taken >= 40) begin
        pressed = 1'b1;
        out_stall <= 1'b1;
        for (held = 0; held < HOLD_OFF_CYCLES; held++) @(negedge clk);
      end
      if ($urandom_range(0, 9) == 0) begin
        // Calm stretch: take every chunk as soon as it shows up.
        out_stall <= 1'b0;
        repeat ($urandom_range(30, 80)) @(negedge clk);
      end else begin
        run = pick_gap();
        if (run > 0) begin
          out_stall <= 1'b1;
          repeat (run) @(negedge clk);
        end
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
  end

  // Producer side: reset, directed corners, then the random mix.
  initial begin : producer
    int                          r;
    int                          gap;
    logic [fpws_pkg::ADDR_W-1:0] start;
    logic [fpws_pkg::CNT_W-1:0]  count;
    rst           = 1'b1;
    in_valid      = 1'b0;
    start_address = '0;
    byte_count    = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Zero count at both ends of the address space: one empty last chunk.
    send_request(24'h000000, 13'd0, 0);
    send_request(24'hFFFFFF, 13'd0, 0);
    // Single bytes, aligned and on the last byte of a page, then two bytes across a page.
    send_request(24'h000000, 13'd1, 0);
    send_request(24'h0000FF, 13'd1, 0);
    send_request(24'h0000FF, 13'd2, 1);
    // Aligned whole pages: no empty trailing chunk.
    send_request(24'h000000, 13'd256, 0);
    send_request(24'h001200, 13'd512, 0);
    send_request(24'h000000, 13'd4096, 0);
    // Partial chunks: unaligned heads, full pages and partial tails.
    send_request(24'h000010, 13'd256, 0);
    send_request(24'h000080, 13'd128, 0);
    send_request(24'h7FFF80, 13'd255, 2);
    send_request(24'h000000, 13'd257, 0);
    send_request(24'hABCDEF, 13'd300, 0);
    send_request(24'h555555, 13'h0AAA, 0);
    // Wrap at the top of the address space, the worst case being 17 chunks.
    send_request(24'hFFFF00, 13'd512, 0);
    send_request(24'hFFFFFF, 13'd4096, 0);
    send_request(24'hFFFFF0, 13'd100, 0);
    // Counts beyond the maximum saturate.
    send_request(24'h000100, 13'd4097, 0);
    send_request(24'h123456, 13'h1FFF, 0);
    send_request(24'hAAAAAA, 13'h1555, 0);

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      r     = $urandom_range(0, 99);
      start = fpws_pkg::ADDR_W'($urandom);
      if (r < 35) begin
        count = fpws_pkg::CNT_W'($urandom_range(1, 300));
      end else if (r < 50) begin
        count = fpws_pkg::CNT_W'($urandom_range(0, fpws_pkg::MAX_BYTES));
      end else if (r < 62) begin
        start = {start[fpws_pkg::ADDR_W-1:fpws_pkg::PAGE_LOG2],
                 {fpws_pkg::PAGE_LOG2{1'b0}}};
        count = fpws_pkg::CNT_W'(fpws_pkg::PAGE_BYTES *
                  $urandom_range(1, fpws_pkg::MAX_BYTES / fpws_pkg::PAGE_BYTES));
      end else if (r < 72) begin
        count = fpws_pkg::CNT_W'($urandom_range(fpws_pkg::MAX_BYTES + 1,
                                                (1 << fpws_pkg::CNT_W) - 1));
      end else if (r < 82) begin
        start = fpws_pkg::ADDR_W'((1 << fpws_pkg::ADDR_W) - 1 - $urandom_range(0, 600));
        count = fpws_pkg::CNT_W'($urandom_range(1, 1024));
      end else if (r < 88) begin
        count = '0;
      end else if (r < 94) begin
        count = fpws_pkg::CNT_W'(fpws_pkg::MAX_BYTES);
      end else begin
        count = fpws_pkg::CNT_W'($urandom);
      end
      // Send a burst with no gaps every so often.
      gap = (i % 40 < 10) ? 0 : pick_gap();
      send_request(start, count, gap);
    end
    in_valid <= 1'b0;

    // Drain every outstanding chunk, then watch a little longer for strays.
    while (book.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (book.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/fpws_pkg.sv
rtl/fpws_seq.sv
rtl/fpws_dp.sv
rtl/flash_page_write_splitter.sv
bench/flash_page_write_splitter_tb.sv
